[src/lowest_free_lease_allocator_top_macros.svh]
// Assertion helpers used by the allocator top module.
`ifndef LOWEST_FREE_LEASE_ALLOCATOR_TOP_MACROS_SVH
`define LOWEST_FREE_LEASE_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LFLA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lfla_pkg.sv]
`timescale 1ns / 1ps

package lfla_pkg;

  // Bank size and counter width
  localparam int NUM_GATES  = 16;
  localparam int COUNT_BITS = 16;

  // Gate index width inside the chain
  localparam int GATE_IDX_W = (NUM_GATES > 1) ? $clog2(NUM_GATES) : 1;
  // gates_in_use register width
  localparam int LIMIT_W    = 5;
  // Common width for index vs limit compare
  localparam int CMP_W      = (GATE_IDX_W > LIMIT_W) ? GATE_IDX_W : LIMIT_W;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Config port
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] ADDR_GATES_IN_USE = '0;
  localparam logic [LIMIT_W-1:0]    GATES_RESET       = 5'd16;

  // Search token handed from cell to cell
  typedef struct packed {
    logic                  valid;
    logic                  found;
    logic [GATE_IDX_W-1:0] pos;
    logic [COUNT_BITS-1:0] cnt;
  } tok_t;

  // Request data broadcast to every cell
  typedef struct packed {
    logic               start;
    logic               restart;
    logic [31:0]        arrival;
    logic [31:0]        departure;
    logic [LIMIT_W-1:0] limit;
  } bcast_t;

endpackage

[src/lfla_cell.sv]
`timescale 1ns / 1ps

// One gate: lease state, use counter and one stage of the search token.
module lfla_cell (
  input  logic            clk,
  input  logic            rst,
  input  lfla_pkg::bcast_t bc,
  input  lfla_pkg::tok_t  tok_in,
  output lfla_pkg::tok_t  tok_out
);

  logic                            busy;
  logic [31:0]                     lease_end;
  logic [lfla_pkg::COUNT_BITS-1:0] count;
  logic [lfla_pkg::COUNT_BITS-1:0] count_inc;
  logic [lfla_pkg::CMP_W-1:0]      pos_x;
  logic [lfla_pkg::CMP_W-1:0]      lim_x;
  logic                            claim;

  // Eligible when this position lies below gates_in_use
  assign pos_x = (lfla_pkg::CMP_W)'(tok_in.pos);
  assign lim_x = (lfla_pkg::CMP_W)'(bc.limit);

  assign claim = tok_in.valid && !tok_in.found && !busy && (pos_x < lim_x);

  // Saturating increment
  assign count_inc = (count == lfla_pkg::CNT_MAX) ? count :
                     count + lfla_pkg::COUNT_BITS'(1);

  // Lease state and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (bc.start) begin
      if (bc.restart) begin
        busy  <= 1'b0;
        count <= '0;
      end else if (busy && (lease_end <= bc.arrival)) begin
        busy <= 1'b0;
      end
    end else if (claim) begin
      busy  <= 1'b1;
      count <= count_inc;
    end
  end

  // Lease end, payload only
  always_ff @(posedge clk) begin
    if (claim) begin
      lease_end <= bc.departure;
    end
  end

  // Token stage: position advances until a gate is found
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out.valid <= tok_in.valid;
      if (claim) begin
        tok_out.found <= 1'b1;
        tok_out.pos   <= tok_in.pos;
        tok_out.cnt   <= count_inc;
      end else begin
        tok_out.found <= tok_in.found;
        tok_out.pos   <= tok_in.found ? tok_in.pos :
                         tok_in.pos + lfla_pkg::GATE_IDX_W'(1);
        tok_out.cnt   <= tok_in.cnt;
      end
    end
  end

endmodule

[src/lowest_free_lease_allocator_top.sv]
`timescale 1ns / 1ps
// Channel | Handshake         | Payload
// input   | in_valid/in_stall | restart, arrival, departure
// output  | out_valid/out_stall | granted, gate, gate_use_count
// config  | APB psel/penable  | gates_in_use at byte 0
//
// A new request is taken only in idle, after the previous result is loaded. Each
// passes through the transfer edge, a step that frees expired leases in every gate,
// the token's walk along the chain one cell per cycle (the launch is the first
// cell's step) and the load of the result register. Reset (rst, synchronous)
// frees all gates, clears counters and sets gates_in_use to 16. The launch waits
// while out_stall holds the previous result.

`include "lowest_free_lease_allocator_top_macros.svh"

module lowest_free_lease_allocator_top (
  input  logic                            clk,
  input  logic                            rst,
  // APB config port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lfla_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // Request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            restart,
  input  logic [31:0]                     arrival,
  input  logic [31:0]                     departure,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            granted,
  output logic [3:0]                      gate,
  output logic [15:0]                     gate_use_count
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_FREE   = 4'b0010,
    S_LAUNCH = 4'b0100,
    S_SCAN   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [lfla_pkg::LIMIT_W-1:0] gates_in_use;
  logic                         req_restart;
  logic [31:0]                  req_arrival;
  logic [31:0]                  req_departure;
  logic                         in_xfer;
  logic                         out_xfer;
  logic                         out_free;
  logic                         launch;
  lfla_pkg::bcast_t             bc;
  lfla_pkg::tok_t               chain [lfla_pkg::NUM_GATES+1];
  lfla_pkg::tok_t               tail;
  logic [7:0]                   pos_w;
  logic [31:0]                  cnt_w;

  // Config register
  assign pready = 1'b1;
  assign prdata = (paddr == lfla_pkg::ADDR_GATES_IN_USE) ? 32'(gates_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gates_in_use <= lfla_pkg::GATES_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == lfla_pkg::ADDR_GATES_IN_USE)) begin
      gates_in_use <= pwdata[lfla_pkg::LIMIT_W-1:0];
    end
  end

  // Handshakes
  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;
  assign launch   = (state == S_LAUNCH) && out_free;

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_xfer) state_next = S_FREE;
      S_FREE:   state_next = S_LAUNCH;
      S_LAUNCH: if (out_free) state_next = S_SCAN;
      S_SCAN:   if (tail.valid) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request hold register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_restart   <= restart;
      req_arrival   <= arrival;
      req_departure <= departure;
    end
  end

  assign bc.start     = (state == S_FREE);
  assign bc.restart   = req_restart;
  assign bc.arrival   = req_arrival;
  assign bc.departure = req_departure;
  assign bc.limit     = gates_in_use;

  // Token enters the first cell
  assign chain[0].valid = launch;
  assign chain[0].found = 1'b0;
  assign chain[0].pos   = '0;
  assign chain[0].cnt   = '0;

  for (genvar g = 0; g < lfla_pkg::NUM_GATES; g++) begin : g_cell
    lfla_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .bc      (bc),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  assign tail  = chain[lfla_pkg::NUM_GATES];
  assign pos_w = 8'(tail.pos);
  assign cnt_w = 32'(tail.cnt);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tail.valid) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      granted        <= tail.found;
      gate           <= tail.found ? pos_w[3:0] : 4'd0;
      gate_use_count <= tail.found ? cnt_w[15:0] : 16'd0;
    end
  end

  // Checks
  `LFLA_ASSERT_NOW(a_tail_out_empty, tail.valid, !out_valid, "result overwritten")
  `LFLA_ASSERT_NEXT(a_accept_frees, in_xfer, state == S_FREE, "accept without free step")
  `LFLA_ASSERT_NOW(a_token_latency, launch, ##(lfla_pkg::NUM_GATES) tail.valid, "token lost")
  `LFLA_ASSERT_NOW(a_gate_in_range, out_valid && granted, {1'b0, gate} < gates_in_use, "gate out of range")
  `LFLA_ASSERT_NOW(a_refused_zero, out_valid && !granted, gate == 4'd0 && gate_use_count == 16'd0, "refusal not zero")

endmodule
